// ----- sv/szdd_pkg.sv -----
// Shared types and constants of the SZDD LZSS token parser.
package szdd_pkg;

	// Width of the internal position counters; results show the low 32 bits
	localparam int POS_W = 32;
	localparam int OUT_POS_W = 32;
	localparam int WIN_W = 12;

	// Ring window start position
	localparam logic [WIN_W-1:0] WIN_START = WIN_W'(4096 - 16);

	// Header layout
	localparam logic [3:0] HDR_MAGIC_END = 4'd3;
	localparam logic [3:0] HDR_SIZE_B0 = 4'd10;
	localparam logic [3:0] HDR_SIZE_B1 = 4'd11;
	localparam logic [3:0] HDR_SIZE_B2 = 4'd12;
	localparam logic [3:0] HDR_LAST = 4'd13;

	// Result kinds
	localparam logic [2:0] KIND_HEADER = 3'd0;
	localparam logic [2:0] KIND_CONTROL = 3'd1;
	localparam logic [2:0] KIND_LITERAL = 3'd2;
	localparam logic [2:0] KIND_MATCH = 3'd3;
	localparam logic [2:0] KIND_BAD_MAGIC = 3'd4;
	localparam logic [2:0] KIND_TRUNCATED = 3'd5;

	// One result beat
	typedef struct packed {
		logic [2:0] kind;
		logic [OUT_POS_W-1:0] in_pos;
		logic [OUT_POS_W-1:0] out_pos;
		logic [WIN_W-1:0] win_pos;
		logic [7:0] byte_val;
		logic [WIN_W-1:0] m_off;
		logic [4:0] m_len;
		logic [31:0] dsize;
		logic s_end;
	} res_t;

	// Expected magic "SZDD"
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		unique case (idx)
			2'd0: m = 8'h53;
			2'd1: m = 8'h5A;
			2'd2: m = 8'h44;
			2'd3: m = 8'h44;
			default: m = 8'h44;
		endcase
		return m;
	endfunction

endpackage

// ----- sv/szdd_parse_core.sv -----
// Parser state and per-byte decode of header and LZSS tokens.
module szdd_parse_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 beat_en,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output logic                 res_valid,
	output szdd_pkg::res_t       res
);
	import szdd_pkg::*;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_BODY = 2'd1;
	localparam logic [1:0] PH_DISCARD = 2'd2;

	logic [1:0]       phase_q, phase_n;
	logic [3:0]       hdr_idx_q, hdr_idx_n;
	logic [31:0]      size_q, size_n;
	logic             magic_fail_q, magic_fail_n;
	logic [7:0]       ctrl_q, ctrl_n;
	logic [3:0]       bit_idx_q, bit_idx_n;
	logic             pair_vld_q, pair_vld_n;
	logic [7:0]       pair_byte_q, pair_byte_n;
	logic [POS_W-1:0] tok_pos_q, tok_pos_n;
	logic [POS_W-1:0] in_cnt_q, in_cnt_n;
	logic [POS_W-1:0] out_cnt_q, out_cnt_n;
	logic [WIN_W-1:0] win_q, win_n;
	logic [4:0]       m_len;

	assign m_len = {1'b0, data_byte[3:0]} + 5'd3;

	// Next state and result for the byte at the input
	always_comb begin
		phase_n = phase_q;
		hdr_idx_n = hdr_idx_q;
		size_n = size_q;
		magic_fail_n = magic_fail_q;
		ctrl_n = ctrl_q;
		bit_idx_n = bit_idx_q;
		pair_vld_n = pair_vld_q;
		pair_byte_n = pair_byte_q;
		tok_pos_n = tok_pos_q;
		in_cnt_n = in_cnt_q;
		out_cnt_n = out_cnt_q;
		win_n = win_q;
		res_valid = 1'b0;
		res.kind = KIND_HEADER;
		res.in_pos = '0;
		res.out_pos = OUT_POS_W'(out_cnt_q);
		res.win_pos = win_q;
		res.byte_val = '0;
		res.m_off = '0;
		res.m_len = '0;
		res.dsize = '0;
		res.s_end = last_byte;

		unique case (phase_q)
			PH_HEADER: begin
				// magic check and size assembly
				if (hdr_idx_q <= HDR_MAGIC_END) begin
					if (data_byte != magic_byte(hdr_idx_q[1:0]))
						magic_fail_n = 1'b1;
				end
				if (hdr_idx_q == HDR_SIZE_B0)
					size_n[7:0] = size_q[7:0] | data_byte;
				if (hdr_idx_q == HDR_SIZE_B1)
					size_n[15:8] = size_q[15:8] | data_byte;
				if (hdr_idx_q == HDR_SIZE_B2)
					size_n[23:16] = size_q[23:16] | data_byte;
				if (hdr_idx_q == HDR_LAST)
					size_n[31:24] = size_q[31:24] | data_byte;

				priority if (hdr_idx_q == HDR_MAGIC_END && magic_fail_n) begin
					res_valid = 1'b1;
					res.kind = KIND_BAD_MAGIC;
					phase_n = PH_DISCARD;
				end else if (hdr_idx_q >= HDR_LAST) begin
					res_valid = 1'b1;
					res.kind = KIND_HEADER;
					res.dsize = size_n;
					phase_n = PH_BODY;
				end else if (last_byte) begin
					res_valid = 1'b1;
					res.kind = magic_fail_n ? KIND_BAD_MAGIC : KIND_TRUNCATED;
				end else begin
					// mid-header byte, no result
				end
				hdr_idx_n = hdr_idx_q + 4'd1;
			end
			PH_BODY: begin
				res.dsize = size_q;
				in_cnt_n = in_cnt_q + POS_W'(1);
				priority if (bit_idx_q[3]) begin
					// control byte
					res_valid = 1'b1;
					res.kind = KIND_CONTROL;
					res.in_pos = OUT_POS_W'(in_cnt_q);
					res.byte_val = data_byte;
					ctrl_n = data_byte;
					bit_idx_n = '0;
				end else if (pair_vld_q) begin
					// second byte of a match pair
					res_valid = 1'b1;
					res.kind = KIND_MATCH;
					res.in_pos = OUT_POS_W'(tok_pos_q);
					res.m_off = {data_byte[7:4], pair_byte_q};
					res.m_len = m_len;
					out_cnt_n = out_cnt_q + POS_W'(m_len);
					win_n = win_q + WIN_W'(m_len);
					pair_vld_n = 1'b0;
					pair_byte_n = '0;
					bit_idx_n = bit_idx_q + 4'd1;
				end else if (ctrl_q[bit_idx_q[2:0]]) begin
					// literal
					res_valid = 1'b1;
					res.kind = KIND_LITERAL;
					res.in_pos = OUT_POS_W'(in_cnt_q);
					res.byte_val = data_byte;
					out_cnt_n = out_cnt_q + POS_W'(1);
					win_n = win_q + WIN_W'(1);
					bit_idx_n = bit_idx_q + 4'd1;
				end else begin
					// first byte of a match pair
					tok_pos_n = in_cnt_q;
					pair_vld_n = 1'b1;
					pair_byte_n = data_byte;
					if (last_byte) begin
						res_valid = 1'b1;
						res.kind = KIND_TRUNCATED;
						res.in_pos = OUT_POS_W'(in_cnt_q);
					end
				end
			end
			PH_DISCARD: begin
				// bytes after a bad magic are dropped
			end
			default: begin
				phase_n = PH_DISCARD;
			end
		endcase

		// end of file returns the parser to its reset state
		if (last_byte) begin
			phase_n = PH_HEADER;
			hdr_idx_n = '0;
			size_n = '0;
			magic_fail_n = 1'b0;
			ctrl_n = '0;
			bit_idx_n = 4'd8;
			pair_vld_n = 1'b0;
			pair_byte_n = '0;
			tok_pos_n = '0;
			in_cnt_n = '0;
			out_cnt_n = '0;
			win_n = WIN_START;
		end

		res_valid = res_valid & beat_en;
	end

	// State registers, updated on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_idx_q <= '0;
			size_q <= '0;
			magic_fail_q <= 1'b0;
			ctrl_q <= '0;
			bit_idx_q <= 4'd8;
			pair_vld_q <= 1'b0;
			pair_byte_q <= '0;
			tok_pos_q <= '0;
			in_cnt_q <= '0;
			out_cnt_q <= '0;
			win_q <= WIN_START;
		end else if (beat_en) begin
			phase_q <= phase_n;
			hdr_idx_q <= hdr_idx_n;
			size_q <= size_n;
			magic_fail_q <= magic_fail_n;
			ctrl_q <= ctrl_n;
			bit_idx_q <= bit_idx_n;
			pair_vld_q <= pair_vld_n;
			pair_byte_q <= pair_byte_n;
			tok_pos_q <= tok_pos_n;
			in_cnt_q <= in_cnt_n;
			out_cnt_q <= out_cnt_n;
			win_q <= win_n;
		end
	end

endmodule

// ----- sv/szdd_out_buf.sv -----
// Result register with a skid stage for the output channel.
module szdd_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  szdd_pkg::res_t push_res,
	output logic           full,
	output logic           out_valid,
	input  logic           out_stall,
	output szdd_pkg::res_t out_res
);
	import szdd_pkg::*;

	res_t main_q, skid_q;
	logic main_vld_q, skid_vld_q;
	logic pop;
	logic main_load;

	assign pop = main_vld_q & ~out_stall;
	assign main_load = ~main_vld_q | pop;
	assign full = skid_vld_q;
	assign out_valid = main_vld_q;
	assign out_res = main_q;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (main_load) begin
			main_vld_q <= skid_vld_q | push;
			skid_vld_q <= skid_vld_q & push;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (main_load) begin
			if (skid_vld_q) begin
				main_q <= skid_q;
				if (push)
					skid_q <= push_res;
			end else if (push) begin
				main_q <= push_res;
			end
		end else if (push) begin
			skid_q <= push_res;
		end
	end

endmodule

// ----- sv/szdd_lzss_token_parser.sv -----
// Top level of the SZDD LZSS token parser.
//
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_stall  | data_byte, last_byte
//  out     | source    | out_valid/out_stall| token_kind .. stream_end
//
// One byte is taken per cycle while in_stall is low; its result, if any, is
// registered in the output buffer. All decode is one combinational step
// from the parser state registers to the result register.
// Reset returns the parser to the start of a file, window at 4080.
// A two-entry output buffer lets input continue while a result waits;
// in_stall rises only when both entries hold results.
module szdd_lzss_token_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  token_kind,
	output logic [31:0] in_position,
	output logic [31:0] out_position,
	output logic [11:0] window_position,
	output logic [7:0]  byte_value,
	output logic [11:0] match_offset,
	output logic [4:0]  match_length,
	output logic [31:0] declared_size,
	output logic        stream_end
);
	import szdd_pkg::*;

	logic beat_en;
	logic res_valid;
	logic buf_full;
	res_t res;
	res_t out_res;

	assign in_stall = buf_full;
	assign beat_en = in_valid & ~buf_full;

	szdd_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat_en   (beat_en),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	szdd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_res  (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign token_kind = out_res.kind;
	assign in_position = out_res.in_pos;
	assign out_position = out_res.out_pos;
	assign window_position = out_res.win_pos;
	assign byte_value = out_res.byte_val;
	assign match_offset = out_res.m_off;
	assign match_length = out_res.m_len;
	assign declared_size = out_res.dsize;
	assign stream_end = out_res.s_end;

endmodule
